### rtl/core/escaped_frame_receiver_crc16_unit_assert.svh
// Assertion macros for the checker file.
`ifndef ESCAPED_FRAME_RECEIVER_CRC16_UNIT_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_CRC16_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define EFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define EFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/efr_pkg.sv
// Types, constants and the CRC fold function of the escaped frame receiver.
package efr_pkg;

	localparam int ByteW = 8;
	localparam int CrcW  = 24;

	localparam logic [ByteW-1:0] SomByte  = 8'hFD;
	localparam logic [ByteW-1:0] EscByte  = 8'hFC;
	localparam logic [ByteW-1:0] EscOr    = 8'h80;
	localparam logic [ByteW-1:0] LenIndex = 8'd9;
	localparam logic [ByteW:0]   LenExtra = 9'd10;
	localparam logic [ByteW-1:0] MaxLenReset = 8'd75;

	localparam logic [CrcW-1:0] CrcSeed = 24'hFFFF00;
	// polynomial with the carry-out bit dropped; the shift removes that bit
	localparam logic [CrcW-1:0] CrcPolyLow = 24'h100200;

	typedef enum logic [2:0] {
		EV_ESC      = 3'd0,
		EV_START    = 3'd1,
		EV_RESTART  = 3'd2,
		EV_BYTE     = 3'd3,
		EV_END      = 3'd4,
		EV_LINE     = 3'd5,
		EV_OVERSIZE = 3'd6,
		EV_STRAY    = 3'd7
	} efr_event_t;

	typedef struct packed {
		logic [ByteW-1:0] rx_byte;
		logic             framing_error;
		logic             overrun_error;
		logic             parity_error;
	} efr_item_t;

	typedef struct packed {
		efr_event_t       event_res;
		logic [ByteW-1:0] byte_value;
		logic [ByteW-1:0] byte_index;
		logic             crc_ok;
	} efr_result_t;

	function automatic logic [CrcW-1:0] crc_fold(input logic [CrcW-1:0] crc,
			input logic [ByteW-1:0] v);
		logic [CrcW-1:0] r;
		r = crc | {{(CrcW-ByteW){1'b0}}, v};
		for (int k = 0; k < ByteW; k++) begin
			r = {r[CrcW-2:0], 1'b0} ^ (r[CrcW-1] ? CrcPolyLow : '0);
		end
		return r;
	endfunction

	localparam logic [CrcW-1:0] CrcStart = crc_fold(CrcSeed, SomByte);

endpackage

### rtl/core/efr_in_if.sv
// Request channel carrying received bytes and their line error flags.
interface efr_in_if;
	import efr_pkg::*;

	logic             valid;
	logic             ready;
	logic [ByteW-1:0] rx_byte;
	logic             framing_error;
	logic             overrun_error;
	logic             parity_error;

	modport source(output valid, rx_byte, framing_error, overrun_error, parity_error,
		input ready);
	modport sink(input valid, rx_byte, framing_error, overrun_error, parity_error,
		output ready);
endinterface

### rtl/core/efr_out_if.sv
// Request channel carrying one receiver event per byte.
interface efr_out_if;
	import efr_pkg::*;

	logic             valid;
	logic             ready;
	logic [2:0]       event_res;
	logic [ByteW-1:0] byte_value;
	logic [ByteW-1:0] byte_index;
	logic             crc_ok;

	modport source(output valid, event_res, byte_value, byte_index, crc_ok,
		input ready);
	modport sink(input valid, event_res, byte_value, byte_index, crc_ok,
		output ready);
endinterface

### rtl/core/efr_frame_ctl.sv
// Frame state, unescaping and CRC update for one byte per cycle while step is high.
module efr_frame_ctl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  efr_pkg::efr_item_t         item,
	input  logic [efr_pkg::ByteW-1:0]  max_frame_len,
	output efr_pkg::efr_result_t       result
);
	import efr_pkg::*;

	logic             in_frame_q, in_frame_n;
	logic             esc_q, esc_n;
	logic [ByteW-1:0] count_q, count_n;
	logic [ByteW-1:0] len_q, len_n;
	logic [CrcW-1:0]  crc_q, crc_n;
	logic             line_err;
	logic [ByteW-1:0] data_b;

	assign line_err = item.framing_error | item.overrun_error | item.parity_error;
	assign data_b   = esc_q ? (item.rx_byte | EscOr) : item.rx_byte;

	always_comb begin
		in_frame_n = in_frame_q;
		esc_n      = esc_q;
		count_n    = count_q;
		len_n      = len_q;
		crc_n      = crc_q;
		result     = '{event_res: EV_STRAY, byte_value: '0, byte_index: '0, crc_ok: 1'b0};
		priority if (line_err) begin
			in_frame_n       = 1'b0;
			result.event_res = EV_LINE;
		end else if (item.rx_byte == SomByte) begin
			result.event_res = in_frame_q ? EV_RESTART : EV_START;
			in_frame_n       = 1'b1;
			count_n          = '0;
			crc_n            = CrcStart;
		end else if (!in_frame_q) begin
			result.event_res = EV_STRAY;
		end else if (item.rx_byte == EscByte) begin
			esc_n            = 1'b1;
			result.event_res = EV_ESC;
		end else if (count_q >= max_frame_len) begin
			in_frame_n       = 1'b0;
			result.event_res = EV_OVERSIZE;
		end else begin
			esc_n             = 1'b0;
			result.byte_index = count_q;
			result.byte_value = data_b;
			len_n             = (count_q == LenIndex) ? data_b : len_q;
			count_n           = count_q + 1'b1;
			crc_n             = crc_fold(crc_q, data_b);
			result.event_res  = EV_BYTE;
			if (count_n > LenIndex && ({1'b0, len_n} + LenExtra) == {1'b0, count_n}) begin
				result.event_res = EV_END;
				result.crc_ok    = (crc_n == '0);
				in_frame_n       = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			count_q    <= '0;
			len_q      <= '0;
			crc_q      <= '0;
		end else if (step) begin
			in_frame_q <= in_frame_n;
			esc_q      <= esc_n;
			count_q    <= count_n;
			len_q      <= len_n;
			crc_q      <= crc_n;
		end
	end
endmodule

### rtl/core/escaped_frame_receiver_crc16_unit.sv
// Top level of the byte-stuffed frame receiver with running CRC.
//
//  channel  dir  payload                                          request when
//  rx       in   rx_byte, framing/overrun/parity error            valid && ready
//  res      out  event_res, byte_value, byte_index, crc_ok        valid && ready
//  cfg      in   max_frame_len                                    cfg_we
//
// One byte per cycle sustained while res is not stalled; an rx request loads the
// input register, then the frame logic writes the result register, which drives
// res valid.
// arst_n clears the pipeline valids, the frame state and sets max_frame_len to 75.
// A stalled res holds the result register; rx keeps taking one more byte into
// the input register, then stalls too.
module escaped_frame_receiver_crc16_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	efr_in_if.sink                    rx,
	efr_out_if.source                 res,
	input  logic                      cfg_we,
	input  logic [efr_pkg::ByteW-1:0] cfg_wdata
);
	import efr_pkg::*;

	logic [ByteW-1:0] max_frame_len_q;
	logic             valid_s1;
	efr_item_t        item_s1;
	logic             res_valid_q;
	efr_result_t      res_q;
	efr_result_t      res_n;
	logic             advance;

	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= MaxLenReset;
		end else if (cfg_we) begin
			max_frame_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rx.valid && rx.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1 <= '{rx_byte: rx.rx_byte, framing_error: rx.framing_error,
				overrun_error: rx.overrun_error, parity_error: rx.parity_error};
		end
		if (advance) begin
			res_q <= res_n;
		end
	end

	efr_frame_ctl u_frame_ctl (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.max_frame_len (max_frame_len_q),
		.result        (res_n)
	);

	assign res.valid      = res_valid_q;
	assign res.event_res  = res_q.event_res;
	assign res.byte_value = res_q.byte_value;
	assign res.byte_index = res_q.byte_index;
	assign res.crc_ok     = res_q.crc_ok;
endmodule

### rtl/core/efr_checker.sv
// Port-level checks on the frame receiver, bound to the top level.
module efr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [2:0]                event_res,
	input logic [efr_pkg::ByteW-1:0] byte_value,
	input logic [efr_pkg::ByteW-1:0] byte_index,
	input logic                      crc_ok
);
	import efr_pkg::*;
	`include "escaped_frame_receiver_crc16_unit_assert.svh"

	`EFR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(event_res), "result dropped or changed while stalled")
	`EFR_ASSERT_NOW(a_crc_only_end, res_valid && crc_ok, event_res == EV_END, "crc_ok outside frame end")
	`EFR_ASSERT_NOW(a_no_data, res_valid && event_res != EV_BYTE && event_res != EV_END, byte_value == '0 && byte_index == '0, "data fields set on non-data event")
	`EFR_ASSERT_NOW(a_end_index, res_valid && event_res == EV_END, byte_index >= LenIndex, "frame end before length byte")
endmodule

bind escaped_frame_receiver_crc16_unit efr_checker u_efr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.event_res  (res.event_res),
	.byte_value (res.byte_value),
	.byte_index (res.byte_index),
	.crc_ok     (res.crc_ok)
);
